// ===== src/ise_pkg.sv =====
package ise_pkg;

   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned POSITION_W = 6;
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 40;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct packed {
      logic load;
      logic pair_left;
      logic shift;
      logic descending;
   } cell_ctrl_type;

   // True when a must be placed after b in the selected order.
   function automatic logic goes_after(value_type a, value_type b, logic descending);
      logic result;
      if (descending) begin
         result = (b > a);
      end else begin
         result = (a > b);
      end
      return result;
   endfunction

endpackage

// ===== src/ise_cell.sv =====
module ise_cell (
   input  logic                   clock,
   input  ise_pkg::cell_ctrl_type ctrl,
   input  ise_pkg::value_type     sample,
   input  ise_pkg::value_type     left_value,
   input  ise_pkg::value_type     right_value,
   input  logic                   swap_in,
   output ise_pkg::value_type     value_out,
   output logic                   swap_out
);

   ise_pkg::value_type value_ff;
   ise_pkg::value_type value_in;

   assign swap_out  = ctrl.pair_left && ise_pkg::goes_after(value_ff, right_value, ctrl.descending);
   assign value_out = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.load) begin
         value_in = sample;
      end else if (swap_out) begin
         value_in = right_value;
      end else if (swap_in) begin
         value_in = left_value;
      end else if (ctrl.shift) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== src/integer_sort_engine.sv =====
// Channel  Direction  Beat contents
// req_     in         tdata: sample_value [31:0]; tlast: final_item
// rsp_     out        tdata: sorted_value [31:0], position [37:32]; tlast: run_end;
//                     tuser: overflowed
// csr_     in         data: descending
//
// Beats fill free cells in order. After the final beat the row of cells sorts by
// odd-even exchange, one round per cycle for n rounds, n being the number of stored
// values; the run of n beats then shifts out of the first cell, one per accepted beat.
// req_tready is high only while loading; a stalled result holds the row in place.
// Reset is synchronous and empties the store; csr_ready is always high.
module integer_sort_engine #(
   parameter int unsigned MAX_ENTRIES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ise_pkg::REQ_DATA_W-1:0]     req_tdata,  // sample_value
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ise_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // sorted_value, position, zeros
   output logic                               rsp_tlast,
   output logic                               rsp_tuser,  // overflowed
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_data
);

   localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT,
      ST_DRAIN
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     round_ff, round_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic              drop_ff, drop_in;
   logic              desc_ff, desc_in;

   ise_pkg::value_type     cell_value [MAX_ENTRIES];
   logic                   cell_swap  [MAX_ENTRIES];
   ise_pkg::cell_ctrl_type cell_ctrl  [MAX_ENTRIES];

   logic req_fire;
   logic rsp_fire;
   logic last_pos;

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_DRAIN);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign last_pos   = (pos_ff == count_ff - CW'(1));

   assign rsp_tdata = {
      {(ise_pkg::RSP_DATA_W - ise_pkg::VALUE_W - ise_pkg::POSITION_W){1'b0}},
      ise_pkg::POSITION_W'(pos_ff),
      cell_value[0]
   };
   assign rsp_tlast = last_pos;
   assign rsp_tuser = drop_ff;

   genvar i;
   generate
      for (i = 0; i < MAX_ENTRIES; i++) begin : g_cell
         ise_pkg::value_type left_v;
         ise_pkg::value_type right_v;
         logic               swap_l;

         if (i == 0) begin : g_first
            assign left_v = '0;
            assign swap_l = 1'b0;
         end else begin : g_mid
            assign left_v = cell_value[i-1];
            assign swap_l = cell_swap[i-1];
         end

         if (i == MAX_ENTRIES - 1) begin : g_last
            assign right_v = '0;
         end else begin : g_notlast
            assign right_v = cell_value[i+1];
         end

         assign cell_ctrl[i].load       = req_fire && (count_ff == CW'(i));
         assign cell_ctrl[i].pair_left  = (state_ff == ST_SORT)
                                          && (1'(i % 2) == round_ff[0])
                                          && (CW'(i + 1) < count_ff);
         assign cell_ctrl[i].shift      = rsp_fire;
         assign cell_ctrl[i].descending = desc_ff;

         ise_cell u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl[i]),
            .sample      (ise_pkg::value_type'(req_tdata)),
            .left_value  (left_v),
            .right_value (right_v),
            .swap_in     (swap_l),
            .value_out   (cell_value[i]),
            .swap_out    (cell_swap[i])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      round_in = round_ff;
      pos_in   = pos_ff;
      drop_in  = drop_ff;
      desc_in  = desc_ff;

      if (csr_valid && csr_ready) begin
         desc_in = csr_data;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (count_ff < CW'(MAX_ENTRIES)) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_SORT;
                  round_in = '0;
               end
            end
         end
         ST_SORT: begin
            round_in = round_ff + CW'(1);
            if (round_ff == count_ff - CW'(1)) begin
               state_in = ST_DRAIN;
               pos_in   = '0;
            end
         end
         ST_DRAIN: begin
            if (rsp_fire) begin
               pos_in = pos_ff + CW'(1);
               if (last_pos) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  drop_in  = 1'b0;
                  pos_in   = '0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         round_ff <= '0;
         pos_ff   <= '0;
         drop_ff  <= 1'b0;
         desc_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         round_ff <= round_in;
         pos_ff   <= pos_in;
         drop_ff  <= drop_in;
         desc_ff  <= desc_in;
      end
   end

endmodule

// ===== dv/tb.sv =====
module tb;

   localparam int unsigned MAX_ENTRIES  = 16;
   localparam int unsigned DRAIN_CYCLES = 2 * MAX_ENTRIES + 8;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned CYCLE_LIMIT  = 100000;
   localparam int unsigned PHASE_ITEMS  = 36;
   localparam int unsigned IDLE_PERCENT = 36;

   typedef struct {
      ise_pkg::value_type value;
      logic               final_item;
   } sample_type;

   typedef struct {
      ise_pkg::value_type             value;
      logic [ise_pkg::POSITION_W-1:0] position;
      logic                           run_end;
      logic                           overflowed;
   } sorted_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ise_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tlast = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ise_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;
   logic                           rsp_tuser;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic                           csr_data = 1'b0;

   sample_type      pending_samples[$];
   sorted_beat_type expected_beats[$];

   ise_pkg::value_type sort_store[MAX_ENTRIES];
   int                 stored_count = 0;
   logic               dropped = 1'b0;
   logic               sort_descending = 1'b0;

   logic       steady = 1'b0;
   logic       want_hold = 1'b0;
   logic       hold_done = 1'b0;
   int         hold_left = 0;
   int         cycle_count = 0;
   int         failures = 0;
   int         sets_sorted = 0;
   int         overflow_sets = 0;
   int         descending_sets = 0;
   int         beats_checked = 0;

   integer_sort_engine #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic logic ranks_after(ise_pkg::value_type a, ise_pkg::value_type b);
      if (sort_descending) begin
         return a < b;
      end
      return a > b;
   endfunction

   // Stores one accepted sample and, on the final one of a set, queues the sorted run.
   task automatic absorb_sample(input ise_pkg::value_type sample, input logic final_item);
      sorted_beat_type    beat;
      ise_pkg::value_type key;
      int                 slot;
      if (stored_count < MAX_ENTRIES) begin
         sort_store[stored_count] = sample;
         stored_count++;
      end else begin
         dropped = 1'b1;
      end
      if (final_item) begin
         for (int i = 1; i < stored_count; i++) begin
            key  = sort_store[i];
            slot = i;
            while (slot > 0 && ranks_after(sort_store[slot-1], key)) begin
               sort_store[slot] = sort_store[slot-1];
               slot--;
            end
            sort_store[slot] = key;
         end
         for (int k = 0; k < stored_count; k++) begin
            beat.value      = sort_store[k];
            beat.position   = k[ise_pkg::POSITION_W-1:0];
            beat.run_end    = (k == stored_count - 1);
            beat.overflowed = dropped;
            expected_beats.push_back(beat);
         end
         sets_sorted++;
         if (dropped) begin
            overflow_sets++;
         end
         if (sort_descending) begin
            descending_sets++;
         end
         stored_count = 0;
         dropped      = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         sort_descending <= csr_data;
      end
   end

   // Sample driver.
   always @(posedge clock) begin
      sample_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_sample(ise_pkg::value_type'(req_tdata), req_tlast);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() != 0
                && (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               item = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= item.value;
               req_tlast  <= item.final_item;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long hold-off of the result side, started by the first beat of the chosen phase.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (want_hold && !hold_done && rsp_tvalid) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      sorted_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected result beat: value %0d",
                      ise_pkg::value_type'(rsp_tdata[31:0]));
               failures++;
            end else begin
               want = expected_beats.pop_front();
               beats_checked++;
               if (ise_pkg::value_type'(rsp_tdata[31:0]) !== want.value) begin
                  $error("sorted_value: expected %0d, got %0d", want.value,
                         ise_pkg::value_type'(rsp_tdata[31:0]));
                  failures++;
               end
               if (rsp_tdata[37:32] !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_tdata[37:32]);
                  failures++;
               end
               if (rsp_tlast !== want.run_end) begin
                  $error("run_end: expected %0b, got %0b", want.run_end, rsp_tlast);
                  failures++;
               end
               if (rsp_tuser !== want.overflowed) begin
                  $error("overflowed: expected %0b, got %0b", want.overflowed, rsp_tuser);
                  failures++;
               end
            end
         end
         rsp_tready <= (hold_left == 0)
                       && (steady || $urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   task automatic add_sample(input ise_pkg::value_type value, input logic final_item);
      sample_type item;
      item.value      = value;
      item.final_item = final_item;
      pending_samples.push_back(item);
   endtask

   function automatic ise_pkg::value_type draw_value();
      case ($urandom_range(0, 3))
         0: return ise_pkg::value_type'($urandom_range(0, 6)) - 3;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7fffffff;
               1: return 32'sh80000000;
               2: return 32'sh00000000;
               default: return 32'shffffffff;
            endcase
         end
         default: return ise_pkg::value_type'($urandom);
      endcase
   endfunction

   task automatic add_random_phase(input int budget);
      int size;
      while (budget > 0) begin
         case ($urandom_range(0, 9))
            0: size = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 4);
            1: size = 1;
            default: size = $urandom_range(2, MAX_ENTRIES);
         endcase
         for (int i = 0; i < size; i++) begin
            add_sample(draw_value(), i == size - 1);
         end
         budget -= size;
      end
   endtask

   task automatic write_order(input logic descending);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= descending;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      do begin
         @(negedge clock);
      end while (pending_samples.size() != 0 || req_tvalid || expected_beats.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("integer_sort_engine: mismatch");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_order(1'b0);

      // Extremes, a single value, equal values, then a full store whose final value is dropped.
      add_sample(32'sh7fffffff, 1'b0);
      add_sample(32'sh80000000, 1'b0);
      add_sample(32'sh00000000, 1'b0);
      add_sample(32'shffffffff, 1'b0);
      add_sample(32'sh00000001, 1'b1);
      add_sample(32'sh80000000, 1'b1);
      add_sample(5, 1'b0);
      add_sample(-3, 1'b0);
      add_sample(5, 1'b1);
      for (int i = 0; i <= MAX_ENTRIES; i++) begin
         add_sample(1000 - 77 * i, i == MAX_ENTRIES);
      end
      settle();

      for (int p = 0; p < 6; p++) begin
         write_order(p % 3 != 1);
         steady    = (p == 3);
         want_hold = (p == 4);
         add_random_phase(PHASE_ITEMS);
         settle();
         steady = 1'b0;
      end

      if (expected_beats.size() != 0) begin
         $error("%0d expected beats never arrived", expected_beats.size());
         failures++;
      end
      $display("Sorted %0d sets (%0d descending, %0d overflowing the store) in %0d beats.",
               sets_sorted, descending_sets, overflow_sets, beats_checked);
      $display("Random gaps on both sides, one gap-free phase and a %0d-cycle result stall.",
               HOLD_CYCLES);
      if (failures == 0) begin
         $display("integer_sort_engine: match");
      end else begin
         $display("integer_sort_engine: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/ise_pkg.sv
src/ise_cell.sv
src/integer_sort_engine.sv
dv/tb.sv
